// ----- rtl/core/bmbp_pkg.sv -----
// ----------------------------------------------------------------------------
// bmbp_pkg
// Shared types and defaults for the bi-mode branch predictor.
// ----------------------------------------------------------------------------
package bmbp_pkg;

   localparam int HISTORY_BITS_DEF      = 14;
   localparam int DIRECTION_ENTRIES_DEF = 16384;
   localparam int CHOICE_ENTRIES_DEF    = 4096;
   localparam int COUNTER_WIDTH_DEF     = 4;

   localparam int PC_INDEX_W  = 12;
   localparam int QUEUE_DEPTH = 2;
   localparam int QCNT_W      = 2;
   localparam int QPTR_W      = 1;

   typedef enum logic {
      OP_PREDICT = 1'b0,
      OP_RESOLVE = 1'b1
   } op_type;

   typedef struct packed {
      op_type                op;
      logic [PC_INDEX_W-1:0] pc_index;
      logic                  taken;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP
   } bk_state_type;

   typedef struct packed {
      logic              clearing;
      logic              lookup;
      logic [QCNT_W-1:0] rq_count;
   } bk_status_type;

endpackage

// ----- rtl/core/bmbp_ram.sv -----
// ----------------------------------------------------------------------------
// bmbp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bmbp_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- rtl/core/bmbp_front.sv -----
// ----------------------------------------------------------------------------
// bmbp_front
// Accepts requests, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module bmbp_front import bmbp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic                  mode,
   input  logic [PC_INDEX_W-1:0] pc_index,
   input  logic                  taken,
   input  logic                  hold,
   output logic                  full,
   output logic                  cmd_valid,
   output cmd_type               cmd,
   input  logic                  cmd_pop
);

   cmd_type             q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                accept;
   cmd_type             cmd_new;

   always_comb begin
      cmd_new.pc_index = pc_index;
      unique case (mode)
         1'b1: begin
            cmd_new.op    = OP_RESOLVE;
            cmd_new.taken = taken;
         end
         default: begin
            cmd_new.op    = OP_PREDICT;
            cmd_new.taken = 1'b0;
         end
      endcase
   end

   assign full      = hold || (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign accept    = push && !full;
   assign cmd_valid = (count_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = accept  ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(accept) - QCNT_W'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

// ----- rtl/core/bmbp_back.sv -----
// ----------------------------------------------------------------------------
// bmbp_back
// Table lookup and update engine with history register and result queue.
// ----------------------------------------------------------------------------
module bmbp_back import bmbp_pkg::*; #(
   parameter int HISTORY_BITS      = HISTORY_BITS_DEF,
   parameter int DIRECTION_ENTRIES = DIRECTION_ENTRIES_DEF,
   parameter int CHOICE_ENTRIES    = CHOICE_ENTRIES_DEF,
   parameter int COUNTER_WIDTH     = COUNTER_WIDTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          cmd_valid,
   input  cmd_type       cmd,
   output logic          cmd_pop,
   output logic          rsp_empty,
   input  logic          rsp_pop,
   output logic          rsp_predict_taken,
   output bk_status_type status
);

   localparam int CIDX_W      = $clog2(CHOICE_ENTRIES);
   localparam int DIDX_W      = $clog2(DIRECTION_ENTRIES);
   localparam int CLR_ENTRIES = (CHOICE_ENTRIES > DIRECTION_ENTRIES) ?
                                CHOICE_ENTRIES : DIRECTION_ENTRIES;
   localparam int CLR_W       = $clog2(CLR_ENTRIES);
   localparam logic [COUNTER_WIDTH-1:0] CTR_MAX = {COUNTER_WIDTH{1'b1}};
   localparam logic [COUNTER_WIDTH-1:0] CTR_MID = CTR_MAX >> 1;

   function automatic logic [COUNTER_WIDTH-1:0] ctr_move(
      input logic [COUNTER_WIDTH-1:0] c,
      input logic                     up
   );
      logic [COUNTER_WIDTH-1:0] r;
      if (up) begin
         r = (c == CTR_MAX) ? c : c + 1'b1;
      end else begin
         r = (c == '0) ? c : c - 1'b1;
      end
      return r;
   endfunction

   bk_state_type            state_ff, state_in;
   logic [CLR_W-1:0]        clr_ff, clr_in;
   logic [HISTORY_BITS-1:0] hist_ff, hist_in;
   cmd_type                 cur_ff;

   logic                     start;
   logic [DIDX_W-1:0]        didx;
   logic [CIDX_W-1:0]        cidx_cur;
   logic                     use_tk;
   logic [COUNTER_WIDTH-1:0] dir_ctr;

   logic                     ch_we, ch_re, tk_we, nt_we, dir_re;
   logic [CIDX_W-1:0]        ch_waddr, ch_raddr;
   logic [DIDX_W-1:0]        dir_waddr;
   logic [COUNTER_WIDTH-1:0] ch_wdata, dir_wdata;
   logic [COUNTER_WIDTH-1:0] ch_rdata, tk_rdata, nt_rdata;

   logic                     rq_push, rq_pop, rq_data;
   logic                     rq_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]        rq_wr_ff, rq_wr_in, rq_rd_ff, rq_rd_in;
   logic [QCNT_W-1:0]        rq_count_ff, rq_count_in;

   // direction index is the history modulo the table size
   assign didx     = DIDX_W'(hist_ff);
   assign cidx_cur = CIDX_W'(cur_ff.pc_index);
   assign start    = (state_ff == ST_IDLE) && cmd_valid &&
                     (rq_count_ff < QCNT_W'(QUEUE_DEPTH));
   assign cmd_pop  = start;

   assign use_tk  = (ch_rdata >= CTR_MID);
   assign dir_ctr = use_tk ? tk_rdata : nt_rdata;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == CLR_W'(CLR_ENTRIES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      ch_we     = 1'b0;
      tk_we     = 1'b0;
      nt_we     = 1'b0;
      ch_re     = 1'b0;
      dir_re    = 1'b0;
      ch_waddr  = cidx_cur;
      ch_raddr  = CIDX_W'(cmd.pc_index);
      dir_waddr = didx;
      ch_wdata  = ctr_move(ch_rdata, cur_ff.taken);
      dir_wdata = ctr_move(dir_ctr, cur_ff.taken);
      rq_push   = 1'b0;
      rq_data   = 1'b0;
      clr_in    = clr_ff;
      hist_in   = hist_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            ch_we     = 1'b1;
            tk_we     = 1'b1;
            nt_we     = 1'b1;
            ch_waddr  = clr_ff[CIDX_W-1:0];
            dir_waddr = clr_ff[DIDX_W-1:0];
            ch_wdata  = '0;
            dir_wdata = '0;
            clr_in    = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            ch_re  = start;
            dir_re = start;
         end
         ST_LOOKUP: begin
            rq_push = 1'b1;
            if (cur_ff.op == OP_RESOLVE) begin
               ch_we   = 1'b1;
               tk_we   = use_tk;
               nt_we   = !use_tk;
               hist_in = {cur_ff.taken, hist_ff[HISTORY_BITS-1:1]};
            end else begin
               rq_data = (dir_ctr >= CTR_MID);
            end
         end
         default: begin
         end
      endcase
   end

   bmbp_ram #(.WIDTH(COUNTER_WIDTH), .DEPTH(CHOICE_ENTRIES)) u_choice (
      .clock   (clock),
      .wr_en   (ch_we),
      .wr_addr (ch_waddr),
      .wr_data (ch_wdata),
      .rd_en   (ch_re),
      .rd_addr (ch_raddr),
      .rd_data (ch_rdata)
   );

   bmbp_ram #(.WIDTH(COUNTER_WIDTH), .DEPTH(DIRECTION_ENTRIES)) u_taken_side (
      .clock   (clock),
      .wr_en   (tk_we),
      .wr_addr (dir_waddr),
      .wr_data (dir_wdata),
      .rd_en   (dir_re),
      .rd_addr (didx),
      .rd_data (tk_rdata)
   );

   bmbp_ram #(.WIDTH(COUNTER_WIDTH), .DEPTH(DIRECTION_ENTRIES)) u_nottaken_side (
      .clock   (clock),
      .wr_en   (nt_we),
      .wr_addr (dir_waddr),
      .wr_data (dir_wdata),
      .rd_en   (dir_re),
      .rd_addr (didx),
      .rd_data (nt_rdata)
   );

   // result queue
   assign rq_pop            = rsp_pop && (rq_count_ff != '0);
   assign rsp_empty         = (rq_count_ff == '0);
   assign rsp_predict_taken = rq_ff[rq_rd_ff];

   always_comb begin
      rq_wr_in    = rq_push ? rq_wr_ff + 1'b1 : rq_wr_ff;
      rq_rd_in    = rq_pop  ? rq_rd_ff + 1'b1 : rq_rd_ff;
      rq_count_in = rq_count_ff + QCNT_W'(rq_push) - QCNT_W'(rq_pop);
   end

   assign status.clearing = (state_ff == ST_CLEAR);
   assign status.lookup   = (state_ff == ST_LOOKUP);
   assign status.rq_count = rq_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_ff      <= '0;
         hist_ff     <= '0;
         rq_wr_ff    <= '0;
         rq_rd_ff    <= '0;
         rq_count_ff <= '0;
      end else begin
         state_ff    <= state_in;
         clr_ff      <= clr_in;
         hist_ff     <= hist_in;
         rq_wr_ff    <= rq_wr_in;
         rq_rd_ff    <= rq_rd_in;
         rq_count_ff <= rq_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         cur_ff <= cmd;
      end
      if (rq_push) begin
         rq_ff[rq_wr_ff] <= rq_data;
      end
   end

endmodule

// ----- rtl/core/bimode_branch_predictor.sv -----
// ----------------------------------------------------------------------------
// bimode_branch_predictor
// Bi-mode branch predictor: choice table by address, two direction tables
// by global history, predict and resolve requests.
// ----------------------------------------------------------------------------
//   channel   direction  handshake        payload
//   request   in         req_push/full    req_mode, req_pc_index, req_taken
//   result    out        rsp_pop/empty    rsp_predict_taken
//
// In the back end each request has its registered table read in ST_IDLE, then
// in ST_LOOKUP the counter update for a resolve and the result write.
// After reset a clearing pass zeroes the tables, one entry per cycle, over
// max(CHOICE_ENTRIES, DIRECTION_ENTRIES) entries (16384 by default);
// req_full stays high meanwhile.
// Two-entry queues sit on both sides; the back end stalls while two results
// wait to be popped.
// ----------------------------------------------------------------------------
module bimode_branch_predictor import bmbp_pkg::*; #(
   parameter int HISTORY_BITS      = HISTORY_BITS_DEF,
   parameter int DIRECTION_ENTRIES = DIRECTION_ENTRIES_DEF,
   parameter int CHOICE_ENTRIES    = CHOICE_ENTRIES_DEF,
   parameter int COUNTER_WIDTH     = COUNTER_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic                  req_mode,
   input  logic [PC_INDEX_W-1:0] req_pc_index,
   input  logic                  req_taken,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic                  rsp_predict_taken
);

   logic          cmd_valid;
   logic          cmd_pop;
   cmd_type       cmd;
   bk_status_type bk_status;

   bmbp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .mode      (req_mode),
      .pc_index  (req_pc_index),
      .taken     (req_taken),
      .hold      (bk_status.clearing),
      .full      (req_full),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   bmbp_back #(
      .HISTORY_BITS      (HISTORY_BITS),
      .DIRECTION_ENTRIES (DIRECTION_ENTRIES),
      .CHOICE_ENTRIES    (CHOICE_ENTRIES),
      .COUNTER_WIDTH     (COUNTER_WIDTH)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd_valid         (cmd_valid),
      .cmd               (cmd),
      .cmd_pop           (cmd_pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_predict_taken (rsp_predict_taken),
      .status            (bk_status)
   );

`ifndef SYNTHESIS
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   // a lookup only starts with room left for its result
   a_lookup_room: assert property (@(posedge clock) disable iff (reset)
      bk_status.lookup |-> (bk_status.rq_count != QCNT_W'(QUEUE_DEPTH)))
      else $error("lookup with full result queue");

   a_clear_no_result: assert property (@(posedge clock) disable iff (reset)
      $fell(bk_status.clearing) |-> rsp_empty)
      else $error("result present at end of clearing pass");

   a_no_pop_clearing: assert property (@(posedge clock) disable iff (reset)
      bk_status.clearing |-> !cmd_pop)
      else $error("request taken during clearing pass");
`endif

endmodule
